// ===== hdl/lpm_pkg.sv =====
// Shared types and constants for the longest-prefix-match route table.
package lpm_pkg;

   localparam int TABLE_DEPTH_DEFAULT = 64;

   localparam int ADDR_W  = 32;
   localparam int PORT_W  = 6;
   localparam int SLOT_W  = 6;
   localparam int COUNT_W = 7;

   localparam logic CMD_WRITE  = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   typedef struct packed {
      logic [ADDR_W-1:0] prefix;
      logic [ADDR_W-1:0] mask;
      logic [ADDR_W-1:0] gateway;
      logic [PORT_W-1:0] port;
   } route_entry_type;

   typedef struct packed {
      logic clear;
      logic valid;
   } best_ctl_type;

endpackage

// ===== hdl/lpm_best.sv =====
// Match test and best-entry tracker fed by the table read stream.
module lpm_best import lpm_pkg::*; #(
   parameter int INDEX_W = 6
) (
   input  logic                  clock,
   input  logic                  reset,
   input  best_ctl_type          ctl,
   input  logic [ADDR_W-1:0]     dest,
   input  route_entry_type       entry,
   input  logic [INDEX_W-1:0]    index,
   output logic                  found,
   output route_entry_type       best_entry,
   output logic [INDEX_W-1:0]    best_index
);

   logic                 found_ff;
   route_entry_type      best_entry_ff;
   logic [INDEX_W-1:0]   best_index_ff;
   logic                 take;

   assign take = ctl.valid && ((dest & entry.mask) == entry.prefix) &&
                 (!found_ff || (entry.mask > best_entry_ff.mask));

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else if (ctl.clear) begin
         found_ff <= 1'b0;
      end else if (take) begin
         found_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!ctl.clear && take) begin
         best_entry_ff <= entry;
         best_index_ff <= index;
      end
   end

   assign found      = found_ff;
   assign best_entry = best_entry_ff;
   assign best_index = best_index_ff;

endmodule

// ===== hdl/longest_prefix_match_table.sv =====
// Longest-prefix-match route table: entry memory, scan sequencer and response register.
// Write: response strobe on the next cycle after accept; busy stays low.
// Lookup: one table read per cycle from slot count-1 down to 0, count = min(entry_count,
//   TABLE_DEPTH); strobe set in ST_FINISH after ST_SCAN and ST_DRAIN; next cycle if count is 0.
// Busy holds off a new request until the lookup ends; the table has a single read port.
// Reset clears the sequencer, match flag, entry_count and strobe; table contents stay undefined.
module longest_prefix_match_table import lpm_pkg::*; #(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic                 req_command,
   input  logic [SLOT_W-1:0]    req_entry_index,
   input  logic [ADDR_W-1:0]    req_entry_prefix,
   input  logic [ADDR_W-1:0]    req_entry_mask,
   input  logic [ADDR_W-1:0]    req_entry_gateway,
   input  logic [PORT_W-1:0]    req_entry_port,
   input  logic [ADDR_W-1:0]    req_dest_addr,
   output logic                 rsp_strobe,
   output logic                 rsp_hit,
   output logic [ADDR_W-1:0]    rsp_gateway,
   output logic [PORT_W-1:0]    rsp_out_port,
   output logic [SLOT_W-1:0]    rsp_match_index,
   input  logic                 csr_we,
   input  logic [COUNT_W-1:0]   csr_wdata
);

   localparam int AW     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW_RAW = $clog2(TABLE_DEPTH + 1);
   localparam int CW     = (CW_RAW > COUNT_W) ? CW_RAW : COUNT_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   state_type            state_ff;
   logic [COUNT_W-1:0]   entry_count_ff;
   logic [ADDR_W-1:0]    dest_ff;
   logic [AW-1:0]        rd_addr_ff;
   logic [AW-1:0]        rd_idx_ff;
   logic                 rd_vld_ff;
   route_entry_type      rd_data_ff;
   route_entry_type      mem [TABLE_DEPTH];

   logic                 rsp_strobe_ff;
   logic                 rsp_hit_ff;
   logic [ADDR_W-1:0]    rsp_gateway_ff;
   logic [PORT_W-1:0]    rsp_out_port_ff;
   logic [SLOT_W-1:0]    rsp_match_index_ff;

   logic                 accept;
   logic                 wr_en;
   logic [CW-1:0]        count_eff;
   route_entry_type      wr_entry;
   best_ctl_type         best_ctl;
   logic                 best_found;
   route_entry_type      best_entry;
   logic [AW-1:0]        best_index;

   assign accept = start && !busy;
   assign busy   = (state_ff != ST_IDLE);
   assign wr_en  = accept && (req_command == CMD_WRITE) &&
                   (32'(req_entry_index) < 32'(TABLE_DEPTH));

   assign count_eff = (CW'(entry_count_ff) > CW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH)
                                                                : CW'(entry_count_ff);

   assign wr_entry.prefix  = req_entry_prefix;
   assign wr_entry.mask    = req_entry_mask;
   assign wr_entry.gateway = req_entry_gateway;
   assign wr_entry.port    = req_entry_port;

   assign best_ctl.clear = accept && (req_command == CMD_LOOKUP);
   assign best_ctl.valid = rd_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= '0;
      end else if (csr_we) begin
         entry_count_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[AW'(req_entry_index)] <= wr_entry;
      end
      rd_data_ff <= mem[rd_addr_ff];
   end

   lpm_best #(
      .INDEX_W (AW)
   ) u_best (
      .clock      (clock),
      .reset      (reset),
      .ctl        (best_ctl),
      .dest       (dest_ff),
      .entry      (rd_data_ff),
      .index      (rd_idx_ff),
      .found      (best_found),
      .best_entry (best_entry),
      .best_index (best_index)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rd_vld_ff     <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         rd_vld_ff     <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  if (req_command == CMD_LOOKUP && count_eff != '0) begin
                     dest_ff    <= req_dest_addr;
                     rd_addr_ff <= AW'(count_eff - CW'(1));
                     state_ff   <= ST_SCAN;
                  end else begin
                     rsp_strobe_ff      <= 1'b1;
                     rsp_hit_ff         <= 1'b0;
                     rsp_gateway_ff     <= '0;
                     rsp_out_port_ff    <= '0;
                     rsp_match_index_ff <= '0;
                  end
               end
            end
            ST_SCAN: begin
               rd_vld_ff <= 1'b1;
               rd_idx_ff <= rd_addr_ff;
               if (rd_addr_ff == '0) begin
                  state_ff <= ST_DRAIN;
               end else begin
                  rd_addr_ff <= rd_addr_ff - AW'(1);
               end
            end
            ST_DRAIN: begin
               state_ff <= ST_FINISH;
            end
            ST_FINISH: begin
               rsp_strobe_ff      <= 1'b1;
               rsp_hit_ff         <= best_found;
               rsp_gateway_ff     <= best_found ? best_entry.gateway : '0;
               rsp_out_port_ff    <= best_found ? best_entry.port : '0;
               rsp_match_index_ff <= best_found ? SLOT_W'(best_index) : '0;
               state_ff           <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_gateway     = rsp_gateway_ff;
   assign rsp_out_port    = rsp_out_port_ff;
   assign rsp_match_index = rsp_match_index_ff;

`ifndef SYNTHESIS
   a_write_word_resp : assert property (@(posedge clock) disable iff (reset)
      (accept && req_command == CMD_WRITE) |=> (rsp_strobe && !rsp_hit))
      else $error("write word without zero response");

   a_miss_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_hit) |->
      (rsp_gateway == '0 && rsp_out_port == '0 && rsp_match_index == '0))
      else $error("miss response carries nonzero fields");

   a_no_resp_in_scan : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN || state_ff == ST_DRAIN) |-> !rsp_strobe)
      else $error("response strobe during table scan");

   a_lookup_busy : assert property (@(posedge clock) disable iff (reset)
      (accept && req_command == CMD_LOOKUP && count_eff != '0) |=> (busy && !rsp_strobe))
      else $error("lookup did not start a scan");
`endif

endmodule
